// File: sv/sst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

  // stream widths, padded to whole bytes
  localparam int IN_W  = 96;
  localparam int OUT_W = 32;
  localparam int KEY_W = 64;
  localparam int IDX_W = 7;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_LOOKUP  = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_SETTYPE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUP       = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_UNDERFLOW = 3'd4
  } st_t;

  localparam logic [1:0] TYP_INTEGER = 2'd0;
  localparam logic [1:0] TYP_BOOLEAN = 2'd1;
  localparam logic [1:0] TYP_NONE    = 2'd2;

  // attribute word as held in memory, level in the top bits
  typedef struct packed {
    logic [4:0] lvl;
    logic [7:0] off;
    logic [1:0] typ;
    logic [1:0] cat;
  } attr_t;

  localparam int ATTR_W = $bits(attr_t);

  typedef struct packed {
    st_t              status;
    logic [IDX_W-1:0] idx;
    logic [4:0]       lvl;
    logic [7:0]       off;
    logic [1:0]       typ;
    logic [1:0]       cat;
  } res_t;

endpackage

`default_nettype wire

// File: sv/sst_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/scoped_symbol_table.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake             payload
// in_      in   in_tvalid/in_tready   in_tdata: cmd, key, level, offset, type, category, count
// out_     out  out_tvalid/out_tready out_tdata: status, index, level, offset, type, category
//
// insert and lookup scan one entry at a time from the newest down to the first key match
// (at most top_count entries); set-type visits every live entry, and remove needs no scan.
// the scan rate is one read per cycle from the key and attribute memories.
// reset (rst_n low, synchronous) empties the table; memory contents are not cleared.
// a finished result waits in the output register; the next transaction is accepted
// while it waits, and a stalled output only holds the next result back.

module scoped_symbol_table #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // cmd[1:0] key[65:2] scope_level[70:66] slot_offset[78:71] type_code[80:79]
  // category[82:81] count[90:83]
  input  logic [sst_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // status[2:0] found_index[9:3] found_level[14:10] found_offset[22:15]
  // found_type[24:23] found_category[26:25]
  output logic [sst_pkg::OUT_W-1:0] out_tdata
);

  import sst_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MW = (CW > 8) ? CW : 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SRCH,
    S_SET,
    S_RESP
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     top_r, top_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  attr_t             new_r, new_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic              issue_r, issue_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pidx_r, pidx_nxt;
  logic [AW-1:0]     nidx_r, nidx_nxt;
  res_t              res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  logic              we_key, we_attr;
  logic [AW-1:0]     wr_addr, rd_addr, first_idx;
  attr_t             wr_attr, rd_attr;
  logic [KEY_W-1:0]  rd_key;
  logic [ATTR_W-1:0] rd_attr_w;
  logic [1:0]        set_typ;
  logic              hit;

  function automatic res_t mk_res(st_t st, logic [AW-1:0] pos, attr_t a);
    res_t r;
    r.status = st;
    r.idx    = IDX_W'(pos);
    r.lvl    = a.lvl;
    r.off    = a.off;
    r.typ    = a.typ;
    r.cat    = a.cat;
    return r;
  endfunction

  function automatic res_t plain(st_t st);
    res_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  // entry store: keys and attributes share read and write addresses
  sst_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_keys (
    .clk   (clk),
    .we    (we_key),
    .waddr (wr_addr),
    .wdata (key_r),
    .raddr (rd_addr),
    .rdata (rd_key)
  );

  sst_ram #(.WIDTH(ATTR_W), .DEPTH(TABLE_DEPTH)) u_attrs (
    .clk   (clk),
    .we    (we_attr),
    .waddr (wr_addr),
    .wdata (wr_attr),
    .raddr (rd_addr),
    .rdata (rd_attr_w)
  );

  assign rd_attr   = attr_t'(rd_attr_w);
  assign hit       = (rd_key == key_r);
  assign set_typ   = (new_r.typ == TYP_BOOLEAN) ? TYP_BOOLEAN : TYP_INTEGER;
  assign first_idx = AW'(top_r - CW'(1));

  // command sequencer
  always_comb begin
    state_nxt     = state_r;
    top_nxt       = top_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    new_nxt       = new_r;
    cnt_nxt       = cnt_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    nidx_nxt      = nidx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    we_key        = 1'b0;
    we_attr       = 1'b0;
    wr_addr       = pidx_r;
    wr_attr       = new_r;
    rd_addr       = nidx_r;

    // output slot drains on transaction
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt     = cmd_t'(in_tdata[1:0]);
          key_nxt     = in_tdata[65:2];
          new_nxt.lvl = in_tdata[70:66];
          new_nxt.off = in_tdata[78:71];
          new_nxt.typ = in_tdata[80:79];
          new_nxt.cat = in_tdata[82:81];
          cnt_nxt     = in_tdata[90:83];
          state_nxt   = S_START;
        end
      end

      S_START: begin
        state_nxt = S_RESP;
        case (cmd_r)
          CMD_INSERT, CMD_LOOKUP: begin
            if (cmd_r == CMD_INSERT && top_r == CW'(TABLE_DEPTH)) begin
              res_nxt = plain(ST_FULL);
            end else if (top_r == '0) begin
              if (cmd_r == CMD_INSERT) begin
                we_key  = 1'b1;
                we_attr = 1'b1;
                wr_addr = AW'(top_r);
                top_nxt = top_r + CW'(1);
                res_nxt = mk_res(ST_OK, AW'(top_r), new_r);
              end else begin
                res_nxt = plain(ST_NOTFOUND);
              end
            end else begin
              // newest entry first
              rd_addr   = first_idx;
              pend_nxt  = 1'b1;
              pidx_nxt  = first_idx;
              issue_nxt = (first_idx != '0);
              nidx_nxt  = first_idx - AW'(1);
              state_nxt = S_SRCH;
            end
          end
          CMD_REMOVE: begin
            if (MW'(cnt_r) > MW'(top_r)) begin
              res_nxt = plain(ST_UNDERFLOW);
            end else begin
              top_nxt = CW'(MW'(top_r) - MW'(cnt_r));
              res_nxt = plain(ST_OK);
            end
          end
          default: begin
            res_nxt = plain(ST_OK);
            if (top_r != '0) begin
              rd_addr   = '0;
              pend_nxt  = 1'b1;
              pidx_nxt  = '0;
              issue_nxt = (top_r > CW'(1));
              nidx_nxt  = AW'(1);
              state_nxt = S_SET;
            end
          end
        endcase
      end

      S_SRCH: begin
        // keep one read in flight ahead of the compare
        pend_nxt = issue_r;
        if (issue_r) begin
          pidx_nxt  = nidx_r;
          issue_nxt = (nidx_r != '0);
          nidx_nxt  = nidx_r - AW'(1);
        end
        if (pend_r && (hit || pidx_r == '0)) begin
          state_nxt = S_RESP;
          if (hit && cmd_r == CMD_LOOKUP) begin
            res_nxt = mk_res(ST_OK, pidx_r, rd_attr);
          end else if (cmd_r == CMD_LOOKUP) begin
            res_nxt = plain(ST_NOTFOUND);
          end else if (hit && rd_attr.lvl == new_r.lvl) begin
            res_nxt = mk_res(ST_DUP, pidx_r, rd_attr);
          end else begin
            // insert goes on top, above every address still being read
            we_key  = 1'b1;
            we_attr = 1'b1;
            wr_addr = AW'(top_r);
            top_nxt = top_r + CW'(1);
            res_nxt = mk_res(ST_OK, AW'(top_r), new_r);
          end
        end
      end

      S_SET: begin
        // read ahead at nidx, write back the entry read last cycle when its type is none
        pend_nxt = issue_r;
        if (issue_r) begin
          pidx_nxt  = nidx_r;
          issue_nxt = ((CW'(nidx_r) + CW'(1)) < top_r);
          nidx_nxt  = nidx_r + AW'(1);
        end
        if (pend_r) begin
          if (rd_attr.typ == TYP_NONE) begin
            we_attr     = 1'b1;
            wr_addr     = pidx_r;
            wr_attr     = rd_attr;
            wr_attr.typ = set_typ;
          end
          if (!issue_r) begin
            state_nxt = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, res_r.cat, res_r.typ, res_r.off, res_r.lvl,
                           res_r.idx, res_r.status};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    new_r      <= new_nxt;
    cnt_r      <= cnt_nxt;
    pidx_r     <= pidx_nxt;
    nidx_r     <= nidx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: sv/sst_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module sst_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [sst_pkg::OUT_W-1:0] out_tdata
);

  import sst_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // one command in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a command is in work");

  // status codes stay in the defined set
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] == ST_OK || out_tdata[2:0] == ST_FULL ||
                   out_tdata[2:0] == ST_DUP || out_tdata[2:0] == ST_NOTFOUND ||
                   out_tdata[2:0] == ST_UNDERFLOW)
    else $error("undefined status code");

  // failures without an entry carry zero fields
  a_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == ST_FULL || out_tdata[2:0] == ST_NOTFOUND ||
                   out_tdata[2:0] == ST_UNDERFLOW) |-> out_tdata[31:3] == '0)
    else $error("nonzero fields on a failed command");

  // nothing presented right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind scoped_symbol_table sst_chk u_sst_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: tb/tb_scoped_symbol_table.sv
`timescale 1ns / 1ps

module tb_scoped_symbol_table;
  import sst_pkg::*;

  localparam int DEPTH      = 128;
  localparam int NUM_ITEMS  = 1350;
  localparam int QUIET_FROM = 1200;
  localparam int CYCLE_CAP  = 1200000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // shadow copy of the symbol table
  logic [KEY_W-1:0] shadow_keys [DEPTH];
  attr_t            shadow_attrs [DEPTH];
  int               shadow_top = 0;

  res_t reply_queue [$];
  int   mismatches  = 0;
  int   items_sent  = 0;
  bit   in_idle_on  = 1'b1;
  bit   out_stall_on = 1'b1;
  int   stall_left  = 0;

  logic [KEY_W-1:0] key_pool [16];
  int               cur_lvl = 0;

  scoped_symbol_table #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // overall watchdog
  initial begin
    repeat (CYCLE_CAP) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  // reply fields taken from one table entry
  function automatic res_t entry_reply(st_t st, int pos);
    res_t r;
    r.status = st;
    r.idx    = IDX_W'(pos);
    r.lvl    = shadow_attrs[pos].lvl;
    r.off    = shadow_attrs[pos].off;
    r.typ    = shadow_attrs[pos].typ;
    r.cat    = shadow_attrs[pos].cat;
    return r;
  endfunction

  // apply one command to the shadow table and return the reply it produces
  function automatic res_t symtab_apply(cmd_t c, logic [63:0] k, logic [4:0] lvl,
                                        logic [7:0] off, logic [1:0] typ,
                                        logic [1:0] cat, logic [7:0] cnt);
    res_t       r;
    int         hit;
    int         i;
    logic [1:0] newt;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    // newest-to-oldest search for the key
    for (i = shadow_top - 1; i >= 0; i--) begin
      if (hit < 0 && shadow_keys[i] == k) hit = i;
    end
    case (c)
      CMD_INSERT: begin
        if (shadow_top >= DEPTH) begin
          r.status = ST_FULL;
        end else if (hit >= 0 && shadow_attrs[hit].lvl == lvl) begin
          r = entry_reply(ST_DUP, hit);
        end else begin
          shadow_keys[shadow_top]  = k;
          shadow_attrs[shadow_top] = '{lvl: lvl, off: off, typ: typ, cat: cat};
          r = entry_reply(ST_OK, shadow_top);
          shadow_top++;
        end
      end
      CMD_LOOKUP: begin
        if (hit >= 0) r = entry_reply(ST_OK, hit);
        else r.status = ST_NOTFOUND;
      end
      CMD_REMOVE: begin
        if (int'(cnt) > shadow_top) r.status = ST_UNDERFLOW;
        else shadow_top -= int'(cnt);
      end
      default: begin
        newt = (typ == TYP_BOOLEAN) ? TYP_BOOLEAN : TYP_INTEGER;
        for (i = 0; i < shadow_top; i++) begin
          if (shadow_attrs[i].typ == TYP_NONE) shadow_attrs[i].typ = newt;
        end
      end
    endcase
    return r;
  endfunction

  // drive one command transaction and record its expected reply on acceptance
  task automatic send_cmd(cmd_t c, logic [63:0] k, logic [4:0] lvl, logic [7:0] off,
                          logic [1:0] typ, logic [1:0] cat, logic [7:0] cnt);
    if (in_idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({cnt, cat, typ, off, lvl, k, c});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    reply_queue.push_back(symtab_apply(c, k, lvl, off, typ, cat, cnt));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic do_insert(logic [63:0] k, logic [4:0] lvl, logic [7:0] off,
                           logic [1:0] typ, logic [1:0] cat);
    send_cmd(CMD_INSERT, k, lvl, off, typ, cat, 8'd0);
  endtask

  task automatic do_lookup(logic [63:0] k);
    send_cmd(CMD_LOOKUP, k, 5'd0, 8'd0, TYP_INTEGER, 2'd0, 8'd0);
  endtask

  task automatic do_remove(logic [7:0] cnt);
    send_cmd(CMD_REMOVE, 64'd0, 5'd0, 8'd0, TYP_INTEGER, 2'd0, cnt);
  endtask

  task automatic do_settype(logic [1:0] typ);
    send_cmd(CMD_SETTYPE, 64'd0, 5'd0, 8'd0, typ, 2'd0, 8'd0);
  endtask

  // result side: random stall bursts on out_tready
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (out_stall_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // compare each result transaction with the oldest expected reply
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_queue.size() == 0) begin
        $error("result transaction with no expected reply: %h", out_tdata);
        mismatches++;
      end else begin
        want = reply_queue.pop_front();
        check_field("status",         8'(want.status), 8'(out_tdata[2:0]));
        check_field("found_index",    8'(want.idx),    8'(out_tdata[9:3]));
        check_field("found_level",    8'(want.lvl),    8'(out_tdata[14:10]));
        check_field("found_offset",   want.off,        out_tdata[22:15]);
        check_field("found_type",     8'(want.typ),    8'(out_tdata[24:23]));
        check_field("found_category", 8'(want.cat),    8'(out_tdata[26:25]));
      end
    end
  end

  // commands on an empty table
  task automatic test_empty_table();
    do_lookup(64'h0123_4567_89ab_cdef);
    do_remove(8'd0);
    do_remove(8'd1);
    do_settype(TYP_BOOLEAN);
  endtask

  // insert extremes, duplicates, shadowing at another level, unused type code
  task automatic test_insert_cases();
    do_insert({64{1'b1}}, 5'b11111, 8'hff, TYP_NONE, 2'd3);
    do_insert(64'd0, 5'd0, 8'd0, TYP_INTEGER, 2'd0);
    do_insert(64'd0, 5'd0, 8'h5a, TYP_BOOLEAN, 2'd1);
    do_insert(64'd0, 5'd15, 8'h11, TYP_NONE, 2'd2);
    do_insert(64'haaaa_5555_aaaa_5555, 5'b10000, 8'h80, 2'd3, 2'd2);
    do_lookup({64{1'b1}});
    do_lookup(64'd0);
    do_lookup(64'haaaa_5555_aaaa_5555);
  endtask

  // set-type mapping for boolean, unused code and none
  task automatic test_set_type();
    do_settype(TYP_BOOLEAN);
    do_insert(64'h5555_aaaa_5555_aaaa, 5'd1, 8'h01, TYP_NONE, 2'd3);
    do_settype(2'd3);
    do_insert(64'h8000_0000_0000_0001, 5'd2, 8'h7f, TYP_NONE, 2'd1);
    do_settype(TYP_NONE);
    do_lookup({64{1'b1}});
    do_lookup(64'h5555_aaaa_5555_aaaa);
    do_lookup(64'h8000_0000_0000_0001);
  endtask

  // pops, including more than are live
  task automatic test_remove();
    do_remove(8'd255);
    do_remove(8'(shadow_top + 1));
    do_remove(8'(shadow_top));
    do_lookup(64'd0);
  endtask

  // fill to capacity, then full insert, deep scans and a full pop
  task automatic test_full_table();
    int i;
    for (i = 0; i < DEPTH; i++) begin
      do_insert({32'hc0de_0000 | 32'(i), $urandom}, 5'($urandom), 8'($urandom),
                2'($urandom_range(0, 3)), 2'($urandom));
    end
    do_insert(64'd7, 5'd3, 8'd3, TYP_INTEGER, 2'd0);
    do_lookup(shadow_keys[0]);
    do_lookup(64'hdead_beef_dead_beef);
    do_settype(TYP_BOOLEAN);
    do_remove(8'(DEPTH + 1));
    do_remove(8'(DEPTH));
  endtask

  // mostly scope-like traffic over a small key pool, with some noise
  task automatic test_random_mix();
    int         sel;
    int         lim;
    logic [4:0] lvl;
    logic [1:0] typ;
    for (sel = 0; sel < 16; sel++) key_pool[sel] = {$urandom, $urandom};
    while (items_sent < NUM_ITEMS) begin
      if (items_sent >= QUIET_FROM) begin
        in_idle_on   = 1'b0;
        out_stall_on = 1'b0;
      end else if (items_sent % 64 == 0) begin
        in_idle_on   = ($urandom_range(0, 2) != 0);
        out_stall_on = ($urandom_range(0, 2) != 0);
      end
      sel = $urandom_range(0, 99);
      if (shadow_top > 112 && $urandom_range(0, 3) == 0) begin
        do_remove(8'($urandom_range(8, shadow_top)));
      end else if (sel < 8) begin
        send_cmd(cmd_t'($urandom_range(0, 3)),
                 ($urandom_range(0, 1) != 0) ? key_pool[$urandom_range(0, 15)]
                                              : {$urandom, $urandom},
                 5'($urandom), 8'($urandom), 2'($urandom), 2'($urandom),
                 8'($urandom_range(0, 255)));
      end else if (sel < 48) begin
        lvl = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'(cur_lvl);
        typ = ($urandom_range(0, 2) == 0) ? TYP_NONE : 2'($urandom_range(0, 3));
        do_insert(key_pool[$urandom_range(0, 15)], lvl, 8'($urandom), typ, 2'($urandom));
      end else if (sel < 75) begin
        if ($urandom_range(0, 4) == 0) do_lookup({$urandom, $urandom});
        else do_lookup(key_pool[$urandom_range(0, 15)]);
      end else if (sel < 90) begin
        lim = (shadow_top < 4) ? shadow_top : 4;
        if ($urandom_range(0, 7) == 0) do_remove(8'(shadow_top + $urandom_range(1, 3)));
        else do_remove(8'($urandom_range(0, lim)));
      end else if (sel < 95) begin
        do_settype(2'($urandom));
      end else begin
        // enter another scope level, no transaction
        cur_lvl = $urandom_range(0, 16) - 1;
      end
    end
  endtask

  initial begin
    int waited;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_table();
    test_insert_cases();
    test_set_type();
    test_remove();
    test_full_table();
    test_random_mix();
    in_tvalid <= 1'b0;

    // drain outstanding replies, then allow for the longest scan
    waited = 0;
    while (reply_queue.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (reply_queue.size() != 0) begin
      $error("%0d expected replies never arrived", reply_queue.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
